>>> hw/rtl/lbqs_pkg.sv
// ----------------------------------------------------------------------------
// lbqs_pkg: shared types and constants of the log-bucket quantile sketch
// Command and status codes, field widths and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package lbqs_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int QFRAC_W   = 16;
  localparam int SCALE_W   = 18;
  localparam int LOG_W     = 13;
  localparam int PROD_W    = LOG_W + SCALE_W;
  localparam int IDX_SHIFT = 16;
  localparam int BKT_OUT_W = 7;
  localparam int OUT_CNT_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd17833;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_NONE  = 2'd0;
  localparam status_t STAT_FOUND = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;
  localparam status_t STAT_MAX   = 2'd3;

  typedef struct packed {
    cmd_t                 cmd;
    logic [SAMPLE_W-1:0]  sample;
    logic [QFRAC_W-1:0]   qfrac;
    logic                 qone;
  } op_t;

  typedef struct packed {
    status_t               status;
    logic [BKT_OUT_W-1:0]  qbucket;
    logic [BKT_OUT_W-1:0]  sbucket;
    logic [OUT_CNT_W-1:0]  total;
    logic [SAMPLE_W-1:0]   min_val;
    logic [SAMPLE_W-1:0]   max_val;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lbqs_ram.sv
// ----------------------------------------------------------------------------
// lbqs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lbqs_front.sv
// ----------------------------------------------------------------------------
// lbqs_front: command intake and bucket classification
// Takes commands, forms log2 in Q.8 and the scaled bucket index over two
// stages, and holds classified commands in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbqs_front #(
  parameter int NUM_BUCKETS = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                accept,
  input  wire lbqs_pkg::op_t                       in_op,
  input  wire logic [lbqs_pkg::SCALE_W-1:0]        scale,
  output logic                                     fe_busy,
  output logic                                     q_valid,
  output lbqs_pkg::op_t                            q_op,
  output logic [$clog2(NUM_BUCKETS)-1:0]           q_bucket,
  input  wire logic                                q_pop
);

  localparam int BW     = $clog2(NUM_BUCKETS);
  localparam int IDX_W  = lbqs_pkg::PROD_W - lbqs_pkg::IDX_SHIFT;
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_BUCKETS - 1);

  // Integer part is the leading-one position; the fraction is the next
  // eight bits below it, zero-filled for small values.
  function automatic logic [lbqs_pkg::LOG_W-1:0] log2_q8(
    input logic [lbqs_pkg::SAMPLE_W-1:0] v
  );
    logic [4:0]                       pos;
    logic [lbqs_pkg::SAMPLE_W+7:0]    sh;
    pos = '0;
    for (int i = 1; i < lbqs_pkg::SAMPLE_W; i++) begin
      if (v[i]) begin
        pos = 5'(i);
      end
    end
    sh = {v, 8'h00} >> pos;
    return {pos, sh[7:0]};
  endfunction

  logic                               s1_v_r;
  lbqs_pkg::op_t                      s1_op_r;
  logic [lbqs_pkg::LOG_W-1:0]         s1_log_r;
  logic                               s2_v_r;
  lbqs_pkg::op_t                      s2_op_r;
  logic [lbqs_pkg::PROD_W-1:0]        s2_prod_r;

  lbqs_pkg::op_t                      qop_mem_r [QDEPTH];
  logic [BW-1:0]                      qbkt_mem_r [QDEPTH];
  logic [PTR_W-1:0]                   wr_ptr_r;
  logic [PTR_W-1:0]                   rd_ptr_r;
  logic [QCNT_W-1:0]                  qcnt_r;

  logic                               q_full;
  logic                               push;
  logic                               s2_free;
  logic                               s1_move;
  logic [IDX_W-1:0]                   idx_raw;
  logic [BW-1:0]                      bkt;

  assign q_full  = (qcnt_r == QCNT_W'(QDEPTH));
  assign push    = s2_v_r & ~q_full;
  assign s2_free = ~s2_v_r | push;
  assign s1_move = s1_v_r & s2_free;
  assign fe_busy = s1_v_r & ~s2_free;

  assign idx_raw = s2_prod_r[lbqs_pkg::PROD_W-1:lbqs_pkg::IDX_SHIFT];
  assign bkt     = (idx_raw > TOP_IDX) ? BW'(NUM_BUCKETS - 1) : idx_raw[BW-1:0];

  assign q_valid  = (qcnt_r != '0);
  assign q_op     = qop_mem_r[rd_ptr_r];
  assign q_bucket = qbkt_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (push) begin
        s2_v_r <= 1'b0;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        qcnt_r <= qcnt_r + 1'b1;
      end else if (!push && q_pop) begin
        qcnt_r <= qcnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_op;
      s1_log_r <= log2_q8(in_op.sample);
    end
    if (s1_move) begin
      s2_op_r   <= s1_op_r;
      s2_prod_r <= lbqs_pkg::PROD_W'(s1_log_r) * lbqs_pkg::PROD_W'(scale);
    end
    if (push) begin
      qop_mem_r[wr_ptr_r]  <= s2_op_r;
      qbkt_mem_r[wr_ptr_r] <= bkt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lbqs_back.sv
// ----------------------------------------------------------------------------
// lbqs_back: command execution against the bucket store
// Bucket read-modify-write for adds, a serial target multiply and bucket
// walk for queries, and a clearing sweep for clear commands and after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lbqs_back #(
  parameter int NUM_BUCKETS = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire lbqs_pkg::op_t               q_op,
  input  wire logic [$clog2(NUM_BUCKETS)-1:0] q_bucket,
  output logic                             q_pop,
  output logic                             init_busy,
  output logic                             res_v_r,
  output lbqs_pkg::res_t                   res_r
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int CW    = COUNT_WIDTH;
  localparam int ACC_W = CW + lbqs_pkg::QFRAC_W;
  localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BUCKETS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;

  function automatic logic [lbqs_pkg::OUT_CNT_W-1:0] sat_out(input logic [CW-1:0] v);
    logic [CW+lbqs_pkg::OUT_CNT_W-1:0] wide;
    wide = {{lbqs_pkg::OUT_CNT_W{1'b0}}, v};
    return (|wide[CW+lbqs_pkg::OUT_CNT_W-1:lbqs_pkg::OUT_CNT_W]) ? '1
           : wide[lbqs_pkg::OUT_CNT_W-1:0];
  endfunction

  function automatic logic [lbqs_pkg::BKT_OUT_W-1:0] bkt_out(input logic [BW-1:0] v);
    return lbqs_pkg::BKT_OUT_W'({{lbqs_pkg::BKT_OUT_W{1'b0}}, v});
  endfunction

  logic [2:0]                      state_r;
  lbqs_pkg::op_t                   op_r;
  logic [BW-1:0]                   bkt_r;
  logic [CW-1:0]                   total_r;
  logic [lbqs_pkg::SAMPLE_W-1:0]   min_r;
  logic [lbqs_pkg::SAMPLE_W-1:0]   max_r;
  logic [CW-1:0]                   target_r;
  logic [ACC_W-1:0]                acc_r;
  logic [lbqs_pkg::QFRAC_W-1:0]    qsh_r;
  logic [3:0]                      mcnt_r;
  logic [CW-1:0]                   run_r;
  logic [BW-1:0]                   rd_idx_r;
  logic                            issue_r;
  logic                            dv_r;
  logic [BW-1:0]                   didx_r;
  logic [BW-1:0]                   sw_idx_r;
  logic                            clr_emit_r;

  logic                            ram_we;
  logic [BW-1:0]                   ram_waddr;
  logic [CW-1:0]                   ram_wdata;
  logic                            ram_re;
  logic [BW-1:0]                   ram_raddr;
  logic [CW-1:0]                   ram_rdata;

  logic [CW-1:0]                   total_nxt;
  logic [lbqs_pkg::SAMPLE_W-1:0]   min_nxt;
  logic [lbqs_pkg::SAMPLE_W-1:0]   max_nxt;
  logic [CW:0]                     run_sum;
  logic [CW-1:0]                   run_nxt;
  logic [ACC_W-1:0]                acc_nxt;

  assign q_pop     = (state_r == ST_IDLE) & q_valid;
  assign init_busy = (state_r == ST_SWEEP) & ~clr_emit_r;

  assign total_nxt = (&total_r) ? total_r : total_r + 1'b1;
  assign min_nxt   = (op_r.sample < min_r) ? op_r.sample : min_r;
  assign max_nxt   = (op_r.sample > max_r) ? op_r.sample : max_r;
  assign run_sum   = {1'b0, run_r} + {1'b0, ram_rdata};
  assign run_nxt   = run_sum[CW] ? '1 : run_sum[CW-1:0];
  // Shift-and-add over the query fraction, most significant bit first.
  assign acc_nxt   = {acc_r[ACC_W-2:0], 1'b0}
                   + (qsh_r[lbqs_pkg::QFRAC_W-1] ? ACC_W'(total_r) : '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bkt_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = q_bucket;
    unique case (state_r)
      ST_IDLE: begin
        ram_re = q_valid;
      end
      ST_ADD: begin
        ram_we    = 1'b1;
        ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
      end
      ST_WALK: begin
        ram_re    = issue_r;
        ram_raddr = rd_idx_r;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_idx_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lbqs_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_BUCKETS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      sw_idx_r   <= '0;
      clr_emit_r <= 1'b0;
      res_v_r    <= 1'b0;
      total_r    <= '0;
      min_r      <= '1;
      max_r      <= '0;
      issue_r    <= 1'b0;
      dv_r       <= 1'b0;
    end else begin
      res_v_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            op_r  <= q_op;
            bkt_r <= q_bucket;
            unique case (q_op.cmd)
              lbqs_pkg::CMD_ADD: begin
                state_r <= ST_ADD;
              end
              lbqs_pkg::CMD_QUERY: begin
                if (total_r == '0) begin
                  res_v_r       <= 1'b1;
                  res_r.status  <= lbqs_pkg::STAT_EMPTY;
                  res_r.qbucket <= '0;
                  res_r.sbucket <= '0;
                  res_r.total   <= sat_out(total_r);
                  res_r.min_val <= min_r;
                  res_r.max_val <= max_r;
                end else if (q_op.qone || (&q_op.qfrac)) begin
                  // A full quantile targets the whole count.
                  target_r <= total_r;
                  rd_idx_r <= '0;
                  issue_r  <= 1'b1;
                  dv_r     <= 1'b0;
                  run_r    <= '0;
                  state_r  <= ST_WALK;
                end else begin
                  acc_r   <= '0;
                  qsh_r   <= q_op.qfrac;
                  mcnt_r  <= '1;
                  state_r <= ST_MUL;
                end
              end
              lbqs_pkg::CMD_CLEAR: begin
                total_r    <= '0;
                min_r      <= '1;
                max_r      <= '0;
                sw_idx_r   <= '0;
                clr_emit_r <= 1'b1;
                state_r    <= ST_SWEEP;
              end
              default: begin
                res_v_r       <= 1'b1;
                res_r.status  <= lbqs_pkg::STAT_NONE;
                res_r.qbucket <= '0;
                res_r.sbucket <= '0;
                res_r.total   <= sat_out(total_r);
                res_r.min_val <= min_r;
                res_r.max_val <= max_r;
              end
            endcase
          end
        end
        ST_ADD: begin
          total_r       <= total_nxt;
          min_r         <= min_nxt;
          max_r         <= max_nxt;
          res_v_r       <= 1'b1;
          res_r.status  <= lbqs_pkg::STAT_NONE;
          res_r.qbucket <= '0;
          res_r.sbucket <= bkt_out(bkt_r);
          res_r.total   <= sat_out(total_nxt);
          res_r.min_val <= min_nxt;
          res_r.max_val <= max_nxt;
          state_r       <= ST_IDLE;
        end
        ST_MUL: begin
          acc_r  <= acc_nxt;
          qsh_r  <= {qsh_r[lbqs_pkg::QFRAC_W-2:0], 1'b0};
          mcnt_r <= mcnt_r - 1'b1;
          if (mcnt_r == '0) begin
            target_r <= acc_nxt[ACC_W-1:lbqs_pkg::QFRAC_W];
            rd_idx_r <= '0;
            issue_r  <= 1'b1;
            dv_r     <= 1'b0;
            run_r    <= '0;
            state_r  <= ST_WALK;
          end
        end
        ST_WALK: begin
          // Reads are issued one bucket ahead of the running sum.
          if (issue_r) begin
            if (rd_idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          dv_r   <= issue_r;
          didx_r <= rd_idx_r;
          if (dv_r) begin
            run_r <= run_nxt;
            if (run_nxt > target_r || didx_r == LAST_IDX) begin
              res_v_r       <= 1'b1;
              res_r.status  <= (run_nxt > target_r) ? lbqs_pkg::STAT_FOUND
                                                    : lbqs_pkg::STAT_MAX;
              res_r.qbucket <= (run_nxt > target_r) ? bkt_out(didx_r) : '0;
              res_r.sbucket <= '0;
              res_r.total   <= sat_out(total_r);
              res_r.min_val <= min_r;
              res_r.max_val <= max_r;
              issue_r       <= 1'b0;
              state_r       <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          sw_idx_r <= sw_idx_r + 1'b1;
          if (sw_idx_r == LAST_IDX) begin
            state_r    <= ST_IDLE;
            clr_emit_r <= 1'b0;
            if (clr_emit_r) begin
              res_v_r       <= 1'b1;
              res_r.status  <= lbqs_pkg::STAT_NONE;
              res_r.qbucket <= '0;
              res_r.sbucket <= '0;
              res_r.total   <= sat_out(total_r);
              res_r.min_val <= min_r;
              res_r.max_val <= max_r;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_ADD || state_r == ST_SWEEP))
    else $error("bucket store written outside an add or a sweep");

  a_found_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && res_r.status == lbqs_pkg::STAT_FOUND) |-> $past(state_r) == ST_WALK)
    else $error("found status issued without a bucket walk");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum with samples recorded");

  a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) |-> (min_r == '1 && max_r == '0))
    else $error("empty sketch holds stale extremes");

endmodule

`default_nettype wire

>>> hw/rtl/log_bucket_quantile_sketch.sv
// ----------------------------------------------------------------------------
// log_bucket_quantile_sketch: logarithmic-bucket histogram with quantiles
// Records samples into log-spaced buckets and answers quantile queries.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge where start is high and busy is low:
// add records in_sample_value, query looks up in_quantile_fraction (or 1.0
// when in_quantile_is_one is set), clear empties the sketch. Every command
// gives one result, shown for a single cycle with out_valid high; the
// receiver cannot hold it off. Results come out in command order.
// The scale register is written through cfg_valid/cfg_data; the user must
// write it only when the block is idle, which the block does not enforce.
// cfg_ready is always high. An add is done in the back end as a bucket
// read, then a write. A query on a non-empty sketch runs a serial multiply
// for its target (skipped when q is one or the fraction is all ones), then
// walks the buckets from the lowest. A clear sweeps the bucket store.
// The front end keeps accepting commands into a two-entry queue while the
// back end works, and raises busy once that queue and the classification
// stages ahead of it are full. After reset the whole bucket store is swept,
// with busy high, before the first command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module log_bucket_quantile_sketch #(
  parameter int NUM_BUCKETS = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_command,
  input  wire logic [lbqs_pkg::SAMPLE_W-1:0]      in_sample_value,
  input  wire logic [lbqs_pkg::QFRAC_W-1:0]       in_quantile_fraction,
  input  wire logic                               in_quantile_is_one,
  output logic                                    out_valid,
  output logic [1:0]                              out_quantile_status,
  output logic [lbqs_pkg::BKT_OUT_W-1:0]          out_quantile_bucket,
  output logic [lbqs_pkg::BKT_OUT_W-1:0]          out_sample_bucket,
  output logic [lbqs_pkg::OUT_CNT_W-1:0]          out_total_count,
  output logic [lbqs_pkg::SAMPLE_W-1:0]           out_min_seen,
  output logic [lbqs_pkg::SAMPLE_W-1:0]           out_max_seen,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lbqs_pkg::SCALE_W-1:0]       cfg_data
);

  localparam int BW = $clog2(NUM_BUCKETS);

  logic [lbqs_pkg::SCALE_W-1:0]  scale_r;
  logic                          accept;
  logic                          fe_busy;
  logic                          init_busy;
  lbqs_pkg::op_t                 in_op;
  logic                          q_valid;
  lbqs_pkg::op_t                 q_op;
  logic [BW-1:0]                 q_bucket;
  logic                          q_pop;
  logic                          res_v;
  lbqs_pkg::res_t                res;

  assign cfg_ready = 1'b1;
  assign busy      = fe_busy | init_busy;
  assign accept    = start & ~busy;

  assign in_op.cmd    = in_command;
  assign in_op.sample = in_sample_value;
  assign in_op.qfrac  = in_quantile_fraction;
  assign in_op.qone   = in_quantile_is_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= lbqs_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  lbqs_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_op    (in_op),
    .scale    (scale_r),
    .fe_busy  (fe_busy),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_bucket (q_bucket),
    .q_pop    (q_pop)
  );

  lbqs_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_bucket  (q_bucket),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .res_v_r   (res_v),
    .res_r     (res)
  );

  assign out_valid           = res_v;
  assign out_quantile_status = res.status;
  assign out_quantile_bucket = res.qbucket;
  assign out_sample_bucket   = res.sbucket;
  assign out_total_count     = res.total;
  assign out_min_seen        = res.min_val;
  assign out_max_seen        = res.max_val;

endmodule

`default_nettype wire

>>> tb/tb_log_bucket_quantile_sketch.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_bucket_quantile_sketch: self-checking bench for the quantile sketch
// Drives add, query, clear and unused commands under several scale settings.
// Each accepted command is run through a software copy of the sketch. Every
// result strobe is compared field by field with the oldest outstanding
// prediction.
// ----------------------------------------------------------------------------

module tb_log_bucket_quantile_sketch;
  import lbqs_pkg::*;

  localparam int          BUCKETS      = 128;
  localparam logic [31:0] COUNT_CEIL   = 32'hFFFF_FFFF;
  localparam cmd_t        CMD_UNUSED   = 2'd3;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          TAIL_CYCLES  = 300;

  // Software copy of the sketch, plus the queue of results still to come.
  class sketch_scoreboard;
    logic [31:0]        bucket_tally [BUCKETS];
    logic [31:0]        sample_count;
    logic [31:0]        low_mark;
    logic [31:0]        high_mark;
    logic [SCALE_W-1:0] scale;
    res_t               awaited [$];
    int                 errors;

    function new();
      scale  = SCALE_RESET;
      errors = 0;
      empty_sketch();
    endfunction

    function void empty_sketch();
      foreach (bucket_tally[i]) bucket_tally[i] = '0;
      sample_count = '0;
      low_mark     = '1;
      high_mark    = '0;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] value);
      scale = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [6:0] bucket_for(logic [31:0] value);
      int          pos;
      logic [7:0]  frac;
      logic [12:0] log_q8;
      logic [63:0] prod;
      if (value == '0) return '0;
      pos = 31;
      while (pos > 0 && !value[pos]) pos--;
      if (pos >= 8) frac = value >> (pos - 8);
      else          frac = value << (8 - pos);
      log_q8 = {pos[4:0], frac};
      prod   = (64'(log_q8) * 64'(scale)) >> IDX_SHIFT;
      return (prod > BUCKETS - 1) ? 7'(BUCKETS - 1) : prod[6:0];
    endfunction

    function res_t apply(op_t op);
      res_t        r;
      logic [6:0]  b;
      logic [16:0] q;
      logic [63:0] target;
      logic [63:0] run;
      r = '0;
      case (op.cmd)
        CMD_ADD: begin
          b = bucket_for(op.sample);
          if (bucket_tally[b] != COUNT_CEIL) bucket_tally[b]++;
          if (sample_count != COUNT_CEIL) sample_count++;
          if (op.sample < low_mark) low_mark = op.sample;
          if (op.sample > high_mark) high_mark = op.sample;
          r.sbucket = b;
        end
        CMD_QUERY: begin
          if (sample_count == '0) begin
            r.status = STAT_EMPTY;
          end else begin
            q = (op.qone || op.qfrac == '1) ? 17'h1_0000 : {1'b0, op.qfrac};
            target   = (64'(sample_count) * 64'(q)) >> 16;
            run      = '0;
            r.status = STAT_MAX;
            for (int i = 0; i < BUCKETS; i++) begin
              run = run + 64'(bucket_tally[i]);
              if (run > 64'(COUNT_CEIL)) run = 64'(COUNT_CEIL);
              if (run > target) begin
                r.status  = STAT_FOUND;
                r.qbucket = i[6:0];
                break;
              end
            end
          end
        end
        CMD_CLEAR: empty_sketch();
        default: ;
      endcase
      r.total   = sample_count;
      r.min_val = low_mark;
      r.max_val = high_mark;
      return r;
    endfunction

    function void note_command(op_t op);
      awaited.push_back(apply(op));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (awaited.size() == 0) begin
        $error("result strobe with no command outstanding");
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      compare_field("quantile_status", 32'(exp_r.status), 32'(got.status));
      compare_field("quantile_bucket", 32'(exp_r.qbucket), 32'(got.qbucket));
      compare_field("sample_bucket", 32'(exp_r.sbucket), 32'(got.sbucket));
      compare_field("total_count", exp_r.total, got.total);
      compare_field("min_seen", exp_r.min_val, got.min_val);
      compare_field("max_seen", exp_r.max_val, got.max_val);
    endfunction
  endclass

  logic                 clk                  = 1'b0;
  logic                 rst_n                = 1'b0;
  logic                 start                = 1'b0;
  logic                 busy;
  logic [1:0]           in_command           = CMD_ADD;
  logic [SAMPLE_W-1:0]  in_sample_value      = '0;
  logic [QFRAC_W-1:0]   in_quantile_fraction = '0;
  logic                 in_quantile_is_one   = 1'b0;
  logic                 out_valid;
  logic [1:0]           out_quantile_status;
  logic [BKT_OUT_W-1:0] out_quantile_bucket;
  logic [BKT_OUT_W-1:0] out_sample_bucket;
  logic [OUT_CNT_W-1:0] out_total_count;
  logic [SAMPLE_W-1:0]  out_min_seen;
  logic [SAMPLE_W-1:0]  out_max_seen;
  logic                 cfg_valid            = 1'b0;
  logic                 cfg_ready;
  logic [SCALE_W-1:0]   cfg_data             = '0;

  sketch_scoreboard sb = new();
  bit               steady = 1'b0;
  int               quiet_cycles = 0;

  log_bucket_quantile_sketch #(
    .NUM_BUCKETS (BUCKETS),
    .COUNT_WIDTH (32)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_sample_value      (in_sample_value),
    .in_quantile_fraction (in_quantile_fraction),
    .in_quantile_is_one   (in_quantile_is_one),
    .out_valid            (out_valid),
    .out_quantile_status  (out_quantile_status),
    .out_quantile_bucket  (out_quantile_bucket),
    .out_sample_bucket    (out_sample_bucket),
    .out_total_count      (out_total_count),
    .out_min_seen         (out_min_seen),
    .out_max_seen         (out_max_seen),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_valid) begin
      got.status  = out_quantile_status;
      got.qbucket = out_quantile_bucket;
      got.sbucket = out_sample_bucket;
      got.total   = out_total_count;
      got.min_val = out_min_seen;
      got.max_val = out_max_seen;
      sb.check_result(got);
    end
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** log_bucket_quantile_sketch: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic op_t make_op(cmd_t c, logic [31:0] s, logic [15:0] qf, logic qo);
    op_t op;
    op.cmd    = c;
    op.sample = s;
    op.qfrac  = qf;
    op.qone   = qo;
    return op;
  endfunction

  function automatic op_t random_op();
    op_t op;
    int  pick;
    op.sample = $urandom;
    op.qfrac  = $urandom;
    op.qone   = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 68)      op.cmd = CMD_ADD;
    else if (pick < 92) op.cmd = CMD_QUERY;
    else if (pick < 96) op.cmd = CMD_CLEAR;
    else                op.cmd = CMD_UNUSED;
    // Spread leading-one positions so every bucket range gets traffic.
    case ($urandom_range(0, 7))
      0: op.sample = '0;
      1: op.sample = $urandom_range(1, 15);
      2: op.sample = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
      default: op.sample = $urandom >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 5))
      0: op.qfrac = '0;
      1: op.qfrac = '1;
      default: ;
    endcase
    return op;
  endfunction

  // Start is left high after a transfer, so back-to-back commands never see
  // it dropped and raised in the same step.
  task automatic send_op(op_t op);
    if (!steady && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 22);
    end
    start                <= 1'b1;
    in_command           <= op.cmd;
    in_sample_value      <= op.sample;
    in_quantile_fraction <= op.qfrac;
    in_quantile_is_one   <= op.qone;
    do @(posedge clk); while (busy);
    sb.note_command(op);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_scale(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_op(random_op());
  endtask

  initial begin : stimulus
    logic [SCALE_W-1:0] scale_plan [$];
    do @(posedge clk); while (!rst_n);

    // Directed part at the reset scale.
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'h8000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_0000, 16'h0000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_0001, 16'h0000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_0002, 16'h0000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_0003, 16'h0000, 1'b0));
    send_op(make_op(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    send_op(make_op(CMD_ADD, 32'h8000_0000, 16'h0000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_01FF, 16'h0000, 1'b0));
    send_op(make_op(CMD_QUERY, 32'hFFFF_FFFF, 16'h0000, 1'b0));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'h8000, 1'b0));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'hFFFF, 1'b0));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'h0000, 1'b1));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'hFFFF, 1'b1));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'hFFFE, 1'b0));
    send_op(make_op(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_op(make_op(CMD_ADD, 32'h5555_5555, 16'hAAAA, 1'b1));
    send_op(make_op(CMD_ADD, 32'hAAAA_AAAA, 16'h5555, 1'b0));
    send_op(make_op(CMD_CLEAR, 32'h0000_0000, 16'h0000, 1'b0));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'h4000, 1'b0));
    send_op(make_op(CMD_ADD, 32'h0000_0005, 16'h0000, 1'b0));
    send_op(make_op(CMD_QUERY, 32'h0000_0000, 16'h0001, 1'b0));

    run_random(170);

    // A zero scale sends every sample to bucket 0.
    scale_plan = '{18'd1024, 18'd256, 18'd0, 18'd1, 18'h3FFFF,
                   18'($urandom_range(1, 262143)), SCALE_RESET};
    foreach (scale_plan[p]) begin
      write_scale(scale_plan[p]);
      steady = (p == 1);
      run_random(150);
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** log_bucket_quantile_sketch: PASSED **");
    end else begin
      $display("** log_bucket_quantile_sketch: FAILED **");
    end
    $finish;
  end

endmodule

>>> log_bucket_quantile_sketch.f
hw/rtl/lbqs_pkg.sv
hw/rtl/lbqs_ram.sv
hw/rtl/lbqs_front.sv
hw/rtl/lbqs_back.sv
hw/rtl/log_bucket_quantile_sketch.sv
tb/tb_log_bucket_quantile_sketch.sv
